// ===== rtl/sat_pkg.sv =====
package sat_pkg;

  // Field widths of the item payloads.
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 10;
  localparam int COUNT_W  = 11;

  // Fan-in of one node of the registered OR tree.
  localparam int TREE_FANIN = 8;

  // Operation codes carried in the input item.
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Status codes carried in the result item.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Strobes that the sequencer broadcasts to every cell of the row.
  typedef struct packed {
    logic cmp;  // latch the compare flags against the broadcast key
    logic ins;  // open a gap at the lower bound and drop the key in
    logic del;  // close the gap at the lower bound
  } ctl_t;

  // Width of one level of the OR tree, level 0 being the leaves.
  function automatic int tree_width(input int leaves, input int level);
    int w;
    w = leaves;
    for (int l = 0; l < level; l++) begin
      w = (w + TREE_FANIN - 1) / TREE_FANIN;
    end
    return w;
  endfunction

  // Number of registered levels needed to bring the leaves down to one node.
  function automatic int tree_levels(input int leaves);
    int w;
    int n;
    w = leaves;
    n = 0;
    while (w > 1) begin
      w = (w + TREE_FANIN - 1) / TREE_FANIN;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/sorted_array_table.sv =====
// Sorted table of signed 32-bit keys held in a row of cells, one entry per cell.
//
// Input channel in_*: one item is one operation, the command in in_tuser and
// the key in in_tdata. Result channel out_*: one item for each operation, with
// the status in out_tuser and the position and entry count in out_tdata.
// Search reports the lowest position holding the key, insert places the key
// before any equal keys, delete removes the lowest matching entry; an
// operation that fails leaves the table as it was.
//
// Once an item is accepted, the cells compare it with their entries; the match
// flags and lower-bound position are then collected from the cells by the
// registered 8-way OR tree of LEVELS levels (4 levels at CAPACITY 1024); then
// the cells shift, the count and result registers are updated, and the result
// is loaded into the output register. Only then is the next item accepted. The
// cells compare and shift in parallel.
//
// Synchronous active-low reset empties the table at once (all cells
// unoccupied, count zero) and drops any pending result. While the receiver
// holds out_tready low the result waits in the output register; the next
// item is still taken and worked on, and its result waits until the slot is free.
module sorted_array_table #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] position, [20:10] entry_count, [23:21] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int DW     = IW + 1;
  localparam int LEVELS = sat_pkg::tree_levels(CAPACITY);
  localparam int TW     = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_TREE,
    S_UPD,
    S_OUT
  } state_t;

  state_t                                 state_r;
  logic [TW-1:0]                          tcnt_r;
  logic [CW-1:0]                          count_r;
  logic [sat_pkg::CMD_W-1:0]              cmd_r;
  logic signed [sat_pkg::VALUE_W-1:0]     key_r;
  logic [sat_pkg::STATUS_W-1:0]           res_status_r;
  logic [sat_pkg::POS_W-1:0]              res_pos_r;
  logic [sat_pkg::COUNT_W-1:0]            res_count_r;
  logic                                   out_tvalid_r;
  logic [sat_pkg::STATUS_W-1:0]           out_status_r;
  logic [sat_pkg::POS_W-1:0]              out_pos_r;
  logic [sat_pkg::COUNT_W-1:0]            out_count_r;

  sat_pkg::ctl_t                          ctl;
  logic signed [sat_pkg::VALUE_W-1:0]     key_w [CAPACITY];
  logic [CAPACITY-1:0]                    lt_w;
  logic [CAPACITY-1:0]                    occ_w;
  logic [CAPACITY-1:0]                    eq_w;
  logic [CAPACITY-1:0]                    bound_w;
  logic [CAPACITY*DW-1:0]                 leaves;
  logic [DW-1:0]                          tree_q;
  logic                                   found;
  logic [IW-1:0]                          lb_pos;
  logic                                   full;
  logic                                   out_free;

  assign in_tready = (state_r == S_IDLE);
  assign found     = tree_q[DW-1];
  assign lb_pos    = tree_q[IW-1:0];
  assign full      = (count_r == CW'(CAPACITY));
  assign out_free  = !out_tvalid_r || out_tready;

  // Strobes to the cells: compare once, then shift only on a successful change.
  always_comb begin
    ctl     = '0;
    ctl.cmp = (state_r == S_CMP);
    ctl.ins = (state_r == S_UPD) && (cmd_r == sat_pkg::CMD_INSERT) && !full;
    ctl.del = (state_r == S_UPD) && (cmd_r == sat_pkg::CMD_DELETE) && found;
  end

  // The row of cells; the ends see an occupied, smaller left side and an empty right side.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sat_pkg::VALUE_W-1:0] lkey;
    logic                               llt;
    logic                               locc;
    logic signed [sat_pkg::VALUE_W-1:0] rkey;
    logic                               rocc;

    if (i == 0) begin : g_left_end
      assign lkey = key_r;
      assign llt  = 1'b1;
      assign locc = 1'b1;
    end else begin : g_left
      assign lkey = key_w[i-1];
      assign llt  = lt_w[i-1];
      assign locc = occ_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_end
      assign rkey = key_w[i];
      assign rocc = 1'b0;
    end else begin : g_right
      assign rkey = key_w[i+1];
      assign rocc = occ_w[i+1];
    end

    sat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key_in    (key_r),
      .left_key  (lkey),
      .left_lt   (llt),
      .left_occ  (locc),
      .right_key (rkey),
      .right_occ (rocc),
      .key_o     (key_w[i]),
      .lt_o      (lt_w[i]),
      .occ_o     (occ_w[i]),
      .eq_o      (eq_w[i]),
      .bound_o   (bound_w[i])
    );

    // Only the lower-bound cell contributes its index and match flag.
    assign leaves[i*DW +: DW] = {bound_w[i] && eq_w[i], bound_w[i] ? IW'(i) : IW'(0)};
  end

  sat_or_tree #(
    .LEAVES (CAPACITY),
    .DW     (DW)
  ) u_tree (
    .clk    (clk),
    .leaves (leaves),
    .result (tree_q)
  );

  // Sequencer, count and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tcnt_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A taken result frees the slot unless a new one is loaded this cycle.
      if (out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            key_r   <= in_tdata;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          tcnt_r  <= '0;
          state_r <= S_TREE;
        end
        S_TREE: begin
          tcnt_r <= tcnt_r + 1'b1;
          if (tcnt_r == TW'(LEVELS - 1)) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          case (cmd_r)
            sat_pkg::CMD_INSERT: begin
              if (full) begin
                res_status_r <= sat_pkg::ST_FULL;
                res_pos_r    <= '0;
                res_count_r  <= sat_pkg::COUNT_W'(count_r);
              end else begin
                res_status_r <= sat_pkg::ST_OK;
                res_pos_r    <= sat_pkg::POS_W'(lb_pos);
                count_r      <= count_r + 1'b1;
                res_count_r  <= sat_pkg::COUNT_W'(count_r + 1'b1);
              end
            end
            sat_pkg::CMD_DELETE: begin
              if (found) begin
                res_status_r <= sat_pkg::ST_OK;
                res_pos_r    <= sat_pkg::POS_W'(lb_pos);
                count_r      <= count_r - 1'b1;
                res_count_r  <= sat_pkg::COUNT_W'(count_r - 1'b1);
              end else begin
                res_status_r <= sat_pkg::ST_MISSING;
                res_pos_r    <= '0;
                res_count_r  <= sat_pkg::COUNT_W'(count_r);
              end
            end
            default: begin
              res_count_r <= sat_pkg::COUNT_W'(count_r);
              if (found) begin
                res_status_r <= sat_pkg::ST_OK;
                res_pos_r    <= sat_pkg::POS_W'(lb_pos);
              end else begin
                res_status_r <= sat_pkg::ST_MISSING;
                res_pos_r    <= '0;
              end
            end
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= res_pos_r;
            out_count_r  <= res_count_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_count_r, out_pos_r};

  // The count never runs past the number of cells.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Between operations the first cell is occupied exactly when the table is not empty.
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (occ_w[0] == (count_r != '0)))
    else $error("first cell occupancy disagrees with count");

  // Between operations the last cell is occupied exactly when the table is full.
  a_tail_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (occ_w[CAPACITY-1] == full))
    else $error("last cell occupancy disagrees with count");

  // An insert that shifts the cells adds exactly one entry.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not advance the count");

  // A delete shift happens only when the lower-bound cell matched.
  a_del_found: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del |-> (found && count_r != '0))
    else $error("delete shift without a matching entry");

endmodule

// ===== rtl/sat_cell.sv =====
module sat_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sat_pkg::ctl_t                        ctl,
  input  logic signed [sat_pkg::VALUE_W-1:0]   key_in,
  input  logic signed [sat_pkg::VALUE_W-1:0]   left_key,
  input  logic                                 left_lt,
  input  logic                                 left_occ,
  input  logic signed [sat_pkg::VALUE_W-1:0]   right_key,
  input  logic                                 right_occ,
  output logic signed [sat_pkg::VALUE_W-1:0]   key_o,
  output logic                                 lt_o,
  output logic                                 occ_o,
  output logic                                 eq_o,
  output logic                                 bound_o
);

  logic signed [sat_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic                               occ_r, occ_nxt;
  logic                               lt_r, lt_nxt;
  logic                               eq_r, eq_nxt;

  // Compare against the broadcast key, then shift with the neighbors.
  // Cells below the lower bound keep their entry; the rest move.
  always_comb begin
    key_nxt = key_r;
    occ_nxt = occ_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.cmp) begin
      lt_nxt = occ_r && (key_r < key_in);
      eq_nxt = occ_r && (key_r == key_in);
    end
    if (ctl.ins && !lt_r) begin
      key_nxt = left_lt ? key_in : left_key;
      occ_nxt = left_occ;
    end
    if (ctl.del && !lt_r) begin
      key_nxt = right_key;
      occ_nxt = right_occ;
    end
  end

  // Occupancy and compare flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      lt_r  <= 1'b0;
      eq_r  <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
    end
  end

  // The stored key is only meaningful while the cell is occupied.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o   = key_r;
  assign lt_o    = lt_r;
  assign occ_o   = occ_r;
  assign eq_o    = eq_r;
  // This cell sits at the lower bound when its left neighbor is below the key and it is not.
  assign bound_o = left_lt && !lt_r;

endmodule

// ===== rtl/sat_or_tree.sv =====
module sat_or_tree #(
  parameter int LEAVES = 1024,
  parameter int DW     = 11
) (
  input  logic                 clk,
  input  logic [LEAVES*DW-1:0] leaves,
  output logic [DW-1:0]        result
);

  localparam int LEVELS = sat_pkg::tree_levels(LEAVES);
  localparam int NODES1 = sat_pkg::tree_width(LEAVES, 1);
  localparam int FANIN  = sat_pkg::TREE_FANIN;

  logic [LEAVES*DW-1:0] lv [LEVELS+1];

  // OR groups of nodes of one level into the nodes of the next.
  function automatic logic [LEAVES*DW-1:0] reduce_level(
    input logic [LEAVES*DW-1:0] v,
    input int                   win,
    input int                   wout
  );
    logic [LEAVES*DW-1:0] r;
    int                   idx;
    r = '0;
    for (int j = 0; j < NODES1; j++) begin
      for (int k = 0; k < FANIN; k++) begin
        idx = j * FANIN + k;
        if (j < wout && idx < win) begin
          r[j*DW +: DW] = r[j*DW +: DW] | v[idx*DW +: DW];
        end
      end
    end
    return r;
  endfunction

  assign lv[0] = leaves;

  // One register per level of the tree.
  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    logic [LEAVES*DW-1:0] node_r;
    always_ff @(posedge clk) begin
      node_r <= reduce_level(lv[l-1], sat_pkg::tree_width(LEAVES, l-1),
                             sat_pkg::tree_width(LEAVES, l));
    end
    assign lv[l] = node_r;
  end

  assign result = lv[LEVELS][DW-1:0];

endmodule

// ===== bench/tb_sorted_array_table.sv =====
module tb_sorted_array_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  // Extra wait once the owed results are back; allow some slack.
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_OPS = 150;

  // The fourth command code is not defined; the block treats it as a search.
  localparam logic [sat_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [sat_pkg::VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [sat_pkg::VALUE_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [sat_pkg::STATUS_W-1:0] status;
    logic [sat_pkg::POS_W-1:0]    position;
    logic [sat_pkg::COUNT_W-1:0]  entry_count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [1:0]  in_tuser;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [9:0] position, [20:10] entry_count, [23:21] zero
  logic [1:0]  out_tuser;  // [1:0] status

  // Keys the table should hold, in ascending signed order.
  logic signed [sat_pkg::VALUE_W-1:0] stored_keys[$];
  // Results owed by the block, oldest first.
  table_result_t pending_results[$];

  int mismatch_count = 0;
  int burst_left = 0;
  int ready_phase_left = 0;
  int ready_style = 0;

  sorted_array_table #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  // Apply one operation to the expected table and return the result it should produce.
  function automatic table_result_t apply_table_op(
    input logic [sat_pkg::CMD_W-1:0]          cmd,
    input logic signed [sat_pkg::VALUE_W-1:0] key
  );
    table_result_t res;
    int lo;
    int hi;
    int mid;
    res = '0;
    res.status = sat_pkg::ST_OK;
    // Lower bound: lowest position whose key is not below the search key.
    lo = 0;
    hi = stored_keys.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (cmd == sat_pkg::CMD_INSERT) begin
      if (stored_keys.size() >= TABLE_DEPTH) begin
        res.status = sat_pkg::ST_FULL;
      end else begin
        stored_keys.insert(lo, key);
        res.position = lo[sat_pkg::POS_W-1:0];
      end
    end else if (lo < stored_keys.size() && stored_keys[lo] == key) begin
      res.position = lo[sat_pkg::POS_W-1:0];
      if (cmd == sat_pkg::CMD_DELETE) begin
        stored_keys.delete(lo);
      end
    end else begin
      res.status = sat_pkg::ST_MISSING;
    end
    res.entry_count = sat_pkg::COUNT_W'(stored_keys.size());
    return res;
  endfunction

  // Send one item, with bursts and random gaps; the expectation is recorded on acceptance.
  task automatic issue_op(input logic [sat_pkg::CMD_W-1:0]          cmd,
                          input logic signed [sat_pkg::VALUE_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_table_op(cmd, key));
  endtask

  // Stop sending and wait until every owed result has come back or the drain limit is reached.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Key choice for the random mix: keys already held most often, small keys for duplicates,
  // the extremes, and values spread over the whole range.
  function automatic logic signed [sat_pkg::VALUE_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && stored_keys.size() != 0) begin
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end else if (r < 65) begin
      return sat_pkg::VALUE_W'($signed($urandom_range(0, 16)) - 8);
    end else if (r < 75) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_MIN + 1;
        3: return KEY_MAX - 1;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom();
  endfunction

  // Every operation on an empty and a small table, extremes, duplicates and misses.
  task automatic test_basic_ops();
    issue_op(sat_pkg::CMD_SEARCH, 0);
    issue_op(sat_pkg::CMD_DELETE, 5);
    issue_op(sat_pkg::CMD_INSERT, 0);
    issue_op(sat_pkg::CMD_INSERT, KEY_MAX);
    issue_op(sat_pkg::CMD_INSERT, KEY_MIN);
    issue_op(sat_pkg::CMD_INSERT, -1);
    issue_op(sat_pkg::CMD_INSERT, 0);
    issue_op(sat_pkg::CMD_INSERT, 32'sh5555_5555);
    issue_op(sat_pkg::CMD_INSERT, 32'shaaaa_aaaa);
    issue_op(sat_pkg::CMD_SEARCH, KEY_MIN);
    issue_op(sat_pkg::CMD_SEARCH, KEY_MAX);
    issue_op(sat_pkg::CMD_SEARCH, 0);
    issue_op(sat_pkg::CMD_SEARCH, 7);
    issue_op(CMD_UNUSED, 0);
    issue_op(CMD_UNUSED, 12345);
    issue_op(sat_pkg::CMD_DELETE, 0);
    issue_op(sat_pkg::CMD_SEARCH, 0);
    issue_op(sat_pkg::CMD_DELETE, 0);
    issue_op(sat_pkg::CMD_DELETE, 0);
    issue_op(sat_pkg::CMD_DELETE, KEY_MAX);
    issue_op(sat_pkg::CMD_DELETE, KEY_MIN);
    issue_op(sat_pkg::CMD_DELETE, -1);
    issue_op(sat_pkg::CMD_DELETE, 32'sh5555_5555);
    issue_op(sat_pkg::CMD_DELETE, 32'shaaaa_aaaa);
    issue_op(sat_pkg::CMD_SEARCH, -1);
    wait_for_results();
  endtask

  // Fill the table to capacity, then push against the full table.
  task automatic test_fill_to_capacity();
    issue_op(sat_pkg::CMD_INSERT, KEY_MIN);
    issue_op(sat_pkg::CMD_INSERT, KEY_MAX);
    while (stored_keys.size() < TABLE_DEPTH) begin
      if ($urandom_range(0, 7) == 0) begin
        issue_op(sat_pkg::CMD_INSERT,
                 stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      end else begin
        issue_op(sat_pkg::CMD_INSERT, $urandom());
      end
    end
    // Full table: inserts are refused, searches still see both ends.
    issue_op(sat_pkg::CMD_INSERT, KEY_MIN);
    issue_op(sat_pkg::CMD_INSERT, 0);
    issue_op(sat_pkg::CMD_SEARCH, KEY_MIN);
    issue_op(sat_pkg::CMD_SEARCH, KEY_MAX);
    issue_op(sat_pkg::CMD_DELETE, KEY_MAX);
    issue_op(sat_pkg::CMD_INSERT, KEY_MAX);
    issue_op(sat_pkg::CMD_INSERT, KEY_MAX);
    issue_op(sat_pkg::CMD_DELETE, KEY_MIN);
    issue_op(sat_pkg::CMD_INSERT, KEY_MIN);
    issue_op(sat_pkg::CMD_DELETE,
             stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    issue_op(sat_pkg::CMD_SEARCH, $urandom());
    wait_for_results();
  endtask

  // Random mix that keeps the table moderately filled.
  task automatic test_random_mix();
    int r;
    int insert_pct;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      insert_pct = (stored_keys.size() < 64) ? 50 : (stored_keys.size() > 400) ? 25 : 40;
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        issue_op(sat_pkg::CMD_INSERT, pick_key());
      end else if (r < insert_pct + 35) begin
        issue_op(sat_pkg::CMD_DELETE, pick_key());
      end else if (r < 95) begin
        issue_op(sat_pkg::CMD_SEARCH, pick_key());
      end else begin
        issue_op(CMD_UNUSED, pick_key());
      end
    end
    wait_for_results();
  endtask

  // Receiver readiness: phases of always ready, coin-flip ready and mostly stalled.
  always @(posedge clk) begin
    if (ready_phase_left == 0) begin
      ready_style = $urandom_range(0, 2);
      ready_phase_left = $urandom_range(16, 96);
    end else begin
      ready_phase_left--;
    end
    case (ready_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: status %0d position %0d count %0d", out_tuser,
                   out_tdata[9:0], out_tdata[20:10]);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status || out_tdata[9:0] !== want.position ||
            out_tdata[20:10] !== want.entry_count || out_tdata[23:21] !== 3'b000) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result differs: expected %0d %0d %0d, got %0d %0d %0d pad %b",
                     want.status, want.position, want.entry_count, out_tuser,
                     out_tdata[9:0], out_tdata[20:10], out_tdata[23:21]);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = sat_pkg::CMD_SEARCH;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_random_mix();
    test_fill_to_capacity();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
